// ===== rtl/core/hipm_pkg.sv =====
// shared constants and types for the homography inverse pixel mapper
`default_nettype none
package hipm_pkg;
   localparam int SRC_ROWS  = 1024;
   localparam int SRC_COLS  = 1024;
   localparam int CW        = 32;
   localparam int PW        = 11;
   localparam int QW        = 12;
   localparam int WW        = 58;
   localparam int NREG      = 8;
   localparam int AW        = 5;
   localparam int ONE_Q30   = 1073741824;

   localparam logic [2:0] REG_ROW_R  = 3'd0;
   localparam logic [2:0] REG_ROW_C  = 3'd1;
   localparam logic [2:0] REG_ROW_K  = 3'd2;
   localparam logic [2:0] REG_COL_R  = 3'd3;
   localparam logic [2:0] REG_COL_C  = 3'd4;
   localparam logic [2:0] REG_COL_K  = 3'd5;
   localparam logic [2:0] REG_PERS_R = 3'd6;
   localparam logic [2:0] REG_PERS_C = 3'd7;

   typedef logic [NREG-1:0][CW-1:0] coef_type;

   localparam logic [CW-1:0] ONE_Q20 = CW'(1 << 20);

   // identity mapping: row weight on row and column weight on column are 1.0
   localparam coef_type COEF_RESET = {CW'(0), CW'(0), CW'(0), ONE_Q20,
                                      CW'(0), CW'(0), CW'(0), ONE_Q20};

   typedef struct packed {
      logic          ok;
      logic [WW-1:0] remu;
      logic [WW-1:0] remv;
      logic [WW-1:0] y;
      logic [QW-1:0] qu;
      logic [QW-1:0] qv;
   } div_stage_type;
endpackage
`default_nettype wire

// ===== rtl/core/homography_inverse_pixel_mapper_top.sv =====
// top level: register file, arithmetic and divider pipelines, output stage
// path from req to rsp: the arith register stages, one divider stage per quotient bit, then the output register
// throughput: one item per cycle while the rsp side is ready, set by the fully pipelined multipliers and divider stages
// each stage has its own valid bit, so bubbles close up under a stalled rsp side
// reset (synchronous, active high) empties the pipeline and loads identity coefficients
`default_nettype none
module homography_inverse_pixel_mapper_top import hipm_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   input  wire logic [PW-1:0] req_out_row,
   input  wire logic [PW-1:0] req_out_col,
   output      logic          rsp_valid,
   input  wire logic          rsp_ready,
   output      logic [PW-1:0] rsp_src_row,
   output      logic [PW-1:0] rsp_src_col,
   output      logic          rsp_inside_res,
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [AW-1:0] csr_paddr,
   input  wire logic [CW-1:0] csr_pwdata,
   output      logic [CW-1:0] csr_prdata,
   output      logic          csr_pready
);
   coef_type      coef_ff;
   logic [2:0]    cidx;
   // arith to divider
   logic          a_valid, a_ready;
   div_stage_type a_data;
   // divider to output stage
   logic          d_valid, d_ready;
   div_stage_type d_data;
   // output register
   logic          out_v_ff;
   logic [PW-1:0] row_ff, col_ff, row_in, col_in;
   logic          ins_ff, ins_in;

   // apb register file, always ready
   assign csr_pready = 1'b1;
   assign cidx       = csr_paddr[4:2];
   assign csr_prdata = coef_ff[cidx];

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         coef_ff[cidx] <= csr_pwdata;
      end
   end

   hipm_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_row    (req_out_row),
      .in_col    (req_out_col),
      .out_valid (a_valid),
      .out_ready (a_ready),
      .out_data  (a_data)
   );

   hipm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid),
      .in_ready  (a_ready),
      .in_data   (a_data),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_data  (d_data)
   );

   // bounds check: strictly inside (0, size) on both axes
   always_comb begin
      ins_in = d_data.ok && (d_data.qu != '0) && (d_data.qv != '0)
               && (d_data.qu < QW'(SRC_ROWS)) && (d_data.qv < QW'(SRC_COLS));
      row_in = ins_in ? d_data.qu[PW-1:0] : '0;
      col_in = ins_in ? d_data.qv[PW-1:0] : '0;
   end

   assign d_ready = !out_v_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (d_ready) begin
         out_v_ff <= d_valid;
      end
      if (d_ready && d_valid) begin
         row_ff <= row_in;
         col_ff <= col_in;
         ins_ff <= ins_in;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_src_row    = row_ff;
   assign rsp_src_col    = col_ff;
   assign rsp_inside_res = ins_ff;
endmodule
`default_nettype wire

// ===== rtl/core/hipm_arith.sv =====
// products, sums and divider setup: three register stages
`default_nettype none
module hipm_arith import hipm_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire coef_type      coef,
   input  wire logic          in_valid,
   output      logic          in_ready,
   input  wire logic [PW-1:0] in_row,
   input  wire logic [PW-1:0] in_col,
   output      logic          out_valid,
   input  wire logic          out_ready,
   output      div_stage_type out_data
);
   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;
   logic signed [43:0] p_in [6];
   logic signed [43:0] p_ff [6];
   logic signed [45:0] nu_in, nv_in, den_in, nu_ff, nv_ff, den_ff;
   div_stage_type d3_in, d3_ff;
   logic [WW-1:0] xu, xv, ylim;

   assign rdy3 = !v3_ff || out_ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      p_in[0] = $signed(coef[REG_ROW_R])  * $signed({1'b0, in_row});
      p_in[1] = $signed(coef[REG_ROW_C])  * $signed({1'b0, in_col});
      p_in[2] = $signed(coef[REG_COL_R])  * $signed({1'b0, in_row});
      p_in[3] = $signed(coef[REG_COL_C])  * $signed({1'b0, in_col});
      p_in[4] = $signed(coef[REG_PERS_R]) * $signed({1'b0, in_row});
      p_in[5] = $signed(coef[REG_PERS_C]) * $signed({1'b0, in_col});
   end

   always_comb begin
      nu_in  = 46'(p_ff[0]) + 46'(p_ff[1]) + 46'($signed(coef[REG_ROW_K]));
      nv_in  = 46'(p_ff[2]) + 46'(p_ff[3]) + 46'($signed(coef[REG_COL_K]));
      den_in = 46'(p_ff[4]) + 46'(p_ff[5]) + 46'(ONE_Q30);
   end

   // x = 2n + d with n = num * 1024, y = 2d, quotient must stay below 4096
   always_comb begin
      xu   = (WW'(unsigned'(nu_ff)) << 11) + WW'(unsigned'(den_ff));
      xv   = (WW'(unsigned'(nv_ff)) << 11) + WW'(unsigned'(den_ff));
      ylim = WW'(unsigned'(den_ff)) << (QW + 1);
      d3_in.ok   = (den_ff > 0) && (nu_ff > 0) && (nv_ff > 0) && (xu < ylim) && (xv < ylim);
      d3_in.remu = xu;
      d3_in.remv = xv;
      d3_in.y    = WW'(unsigned'(den_ff)) << 1;
      d3_in.qu   = '0;
      d3_in.qv   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
      if (rdy1 && in_valid) p_ff <= p_in;
      if (rdy2 && v1_ff) begin
         nu_ff  <= nu_in;
         nv_ff  <= nv_in;
         den_ff <= den_in;
      end
      if (rdy3 && v2_ff) d3_ff <= d3_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = d3_ff;
endmodule
`default_nettype wire

// ===== rtl/core/hipm_div.sv =====
// restoring divider, one quotient bit per stage for both coordinates
`default_nettype none
module hipm_div import hipm_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output      logic          in_ready,
   input  wire div_stage_type in_data,
   output      logic          out_valid,
   input  wire logic          out_ready,
   output      div_stage_type out_data
);
   logic          v_ff  [QW];
   div_stage_type d_ff  [QW];
   div_stage_type d_in  [QW];
   logic          rdy   [QW+1];
   logic          pv    [QW];
   div_stage_type pd    [QW];

   assign rdy[QW] = out_ready;

   for (genvar i = 0; i < QW; i++) begin : g_stage
      localparam int B = QW - 1 - i;
      logic [WW-1:0] t;
      if (i == 0) begin : g_first
         assign pv[i] = in_valid;
         assign pd[i] = in_data;
      end else begin : g_next
         assign pv[i] = v_ff[i-1];
         assign pd[i] = d_ff[i-1];
      end
      assign rdy[i] = !v_ff[i] || rdy[i+1];
      assign t = pd[i].y << B;
      always_comb begin
         d_in[i] = pd[i];
         if (pd[i].remu >= t) begin
            d_in[i].remu  = pd[i].remu - t;
            d_in[i].qu[B] = 1'b1;
         end
         if (pd[i].remv >= t) begin
            d_in[i].remv  = pd[i].remv - t;
            d_in[i].qv[B] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            v_ff[i] <= pv[i];
         end
         if (rdy[i] && pv[i]) d_ff[i] <= d_in[i];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[QW-1];
   assign out_data  = d_ff[QW-1];
endmodule
`default_nettype wire
